>>> design/lzwc_pkg.sv
// Shared types, constants and codes of the variable-width LZW compressor.
package lzwc_pkg;

    localparam int TABLE_SIZE_DEF    = 18041;
    localparam int MAX_CODE_BITS_DEF = 14;

    localparam int        WORD_BITS = 16;
    localparam int        WIDTH_W   = 4;
    localparam int        BF_W      = 5;
    localparam logic [8:0] GROW_CODE  = 9'd256;
    localparam logic [8:0] END_CODE   = 9'd257;
    localparam logic [8:0] RESET_CODE = 9'd258;
    localparam logic [8:0] FIRST_FREE = 9'd259;
    localparam logic [WIDTH_W-1:0] MIN_WIDTH = 4'd9;

    typedef enum logic [1:0] {
        PUT_PREFIX,
        PUT_GROW,
        PUT_RESET,
        PUT_END
    } t_put_sel;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_READ,
        S_CMP,
        S_PUT_PREFIX,
        S_PUT_GROW,
        S_PUT_RESET,
        S_TAIL,
        S_PUT_LASTP,
        S_PUT_END,
        S_FLUSH,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic     load;
        logic     first;
        logic     hash;
        logic     rd;
        logic     step;
        logic     hit;
        logic     insert;
        logic     put;
        t_put_sel put_sel;
        logic     restart;
        logic     grow;
        logic     dict_reset;
        logic     flush;
        logic     finish;
        logic     stream_reset;
        logic     clr_wr;
    } t_cmd;

    typedef struct packed {
        logic have_prefix;
        logic last;
        logic entry_valid;
        logic entry_match;
        logic width_full;
        logic at_max;
        logic out_free;
        logic clr_done;
    } t_sts;

endpackage

>>> design/lzwc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lzwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/lzwc_datapath.sv
// Datapath: dictionary memory, prefix and code state, bit packer and output registers.
module lzwc_datapath #(
    parameter int TABLE_SIZE    = lzwc_pkg::TABLE_SIZE_DEF,
    parameter int MAX_CODE_BITS = lzwc_pkg::MAX_CODE_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lzwc_pkg::t_cmd  i_cmd,
    output lzwc_pkg::t_sts  o_sts,
    input  logic [7:0]      i_data_byte,
    input  logic            i_last_byte,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [15:0]     o_packed_word,
    output logic            o_last_of_run,
    output logic            o_end_of_stream
);

    localparam int CW = MAX_CODE_BITS;
    localparam int AW = $clog2(TABLE_SIZE);
    localparam int EW = 1 + CW + CW + 8;
    localparam logic [AW-1:0] TSZ = AW'(TABLE_SIZE);

    logic [7:0]                     r_sym;
    logic                           r_last;
    logic [CW-1:0]                  r_prefix, n_prefix;
    logic                           r_have;
    logic [CW:0]                    r_nfc;
    logic [lzwc_pkg::WIDTH_W-1:0]   r_width;
    logic [15:0]                    r_acc, n_acc;
    logic [lzwc_pkg::BF_W-1:0]      r_bf, n_bf;
    logic [AW-1:0]                  r_idx, r_step, r_clr_addr;
    logic                           r_pend_valid;
    logic [15:0]                    r_pend_word;
    logic                           r_out_valid, r_out_last, r_out_eos;
    logic [15:0]                    r_out_word;

    logic [EW-1:0]   rdata, wdata;
    logic            we;
    logic [AW-1:0]   waddr;
    logic [CW-1:0]   sym_sh, code, code_m, mask;
    logic [AW-1:0]   hidx;
    logic [lzwc_pkg::BF_W-1:0] w5;
    logic            emit, push;
    logic [15:0]     word;
    logic            out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // Hash index is below 2^CW, so no modulo reduction is needed.
    assign sym_sh = CW'(r_sym) << (r_width - 4'd8);
    assign hidx   = AW'(sym_sh ^ r_prefix);

    always_comb begin
        case (i_cmd.put_sel)
            lzwc_pkg::PUT_PREFIX: code = r_prefix;
            lzwc_pkg::PUT_GROW:   code = CW'(lzwc_pkg::GROW_CODE);
            lzwc_pkg::PUT_RESET:  code = CW'(lzwc_pkg::RESET_CODE);
            lzwc_pkg::PUT_END:    code = CW'(lzwc_pkg::END_CODE);
            default:              code = r_prefix;
        endcase
    end

    assign mask   = (CW'(1) << r_width) - CW'(1);
    assign code_m = code & mask;
    assign w5     = {1'b0, r_width};

    always_comb begin
        emit  = 1'b0;
        word  = r_acc;
        n_acc = r_acc;
        n_bf  = r_bf;
        if (i_cmd.put) begin
            if (r_bf >= w5) begin
                n_acc = (r_acc << r_width) | 16'(code_m);
                if (r_bf == w5) begin
                    emit = 1'b1;
                    word = n_acc;
                    n_bf = 5'd16;
                end else begin
                    n_bf = r_bf - w5;
                end
            end else begin
                emit  = 1'b1;
                word  = (r_acc << r_bf) | 16'(code_m >> (w5 - r_bf));
                n_acc = 16'(code_m);
                n_bf  = r_bf + 5'd16 - w5;
            end
        end else if (i_cmd.flush && r_bf != 5'd16) begin
            emit = 1'b1;
            word = r_acc << r_bf;
            n_bf = 5'd16;
        end
    end

    assign push = (emit && r_pend_valid) || (i_cmd.finish && r_pend_valid);

    always_comb begin
        n_prefix = r_prefix;
        if (i_cmd.first || i_cmd.restart) begin
            n_prefix = CW'(r_sym);
        end else if (i_cmd.hit) begin
            n_prefix = rdata[2*CW+7 -: CW];
        end
    end

    always_comb begin
        we    = 1'b0;
        waddr = r_idx;
        wdata = {1'b1, r_nfc[CW-1:0], r_prefix, r_sym};
        if (i_cmd.clr_wr) begin
            we    = 1'b1;
            waddr = r_clr_addr;
            wdata = '0;
        end else if (i_cmd.insert) begin
            we = 1'b1;
        end
    end

    lzwc_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_SIZE)
    ) u_dict (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (r_idx),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix     <= '0;
            r_have       <= 1'b0;
            r_nfc        <= (CW+1)'(lzwc_pkg::FIRST_FREE);
            r_width      <= lzwc_pkg::MIN_WIDTH;
            r_acc        <= '0;
            r_bf         <= 5'd16;
            r_clr_addr   <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr_addr <= (r_clr_addr == TSZ - 1'b1) ? '0 : r_clr_addr + 1'b1;
            end
            if (emit) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.finish) begin
                r_pend_valid <= 1'b0;
            end
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.stream_reset) begin
                r_prefix <= '0;
                r_have   <= 1'b0;
                r_nfc    <= (CW+1)'(lzwc_pkg::FIRST_FREE);
                r_width  <= lzwc_pkg::MIN_WIDTH;
                r_acc    <= '0;
                r_bf     <= 5'd16;
            end else begin
                r_prefix <= n_prefix;
                r_acc    <= n_acc;
                r_bf     <= n_bf;
                if (i_cmd.first) begin
                    r_have <= 1'b1;
                end
                if (i_cmd.dict_reset) begin
                    r_nfc   <= (CW+1)'(lzwc_pkg::FIRST_FREE);
                    r_width <= lzwc_pkg::MIN_WIDTH;
                end else begin
                    if (i_cmd.insert) begin
                        r_nfc <= r_nfc + 1'b1;
                    end
                    if (i_cmd.grow) begin
                        r_width <= r_width + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sym  <= i_data_byte;
            r_last <= i_last_byte;
        end
        if (i_cmd.hash) begin
            r_idx  <= hidx;
            r_step <= (hidx == '0) ? AW'(1) : TSZ - hidx;
        end else if (i_cmd.step) begin
            r_idx <= (r_idx >= r_step) ? r_idx - r_step : r_idx + (TSZ - r_step);
        end
        if (emit) begin
            r_pend_word <= word;
        end
        if (push) begin
            r_out_word <= r_pend_word;
            r_out_last <= i_cmd.finish;
            r_out_eos  <= i_cmd.finish && r_last;
        end
    end

    assign o_sts.have_prefix = r_have;
    assign o_sts.last        = r_last;
    assign o_sts.entry_valid = rdata[EW-1];
    assign o_sts.entry_match = (rdata[CW+7:8] == r_prefix) && (rdata[7:0] == r_sym);
    assign o_sts.width_full  = (r_nfc >> r_width) != '0;
    assign o_sts.at_max      = r_nfc[CW];
    assign o_sts.out_free    = out_free;
    assign o_sts.clr_done    = (r_clr_addr == TSZ - 1'b1);

    assign o_out_valid     = r_out_valid;
    assign o_packed_word   = r_out_word;
    assign o_last_of_run   = r_out_last;
    assign o_end_of_stream = r_out_eos;

    a_bits_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bf != 5'd0 && r_bf <= 5'd16)
        else $error("bit packer free count out of range");

    a_width_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_width >= lzwc_pkg::MIN_WIDTH && 32'(r_width) <= CW)
        else $error("code width out of range");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> out_free)
        else $error("output word overwritten before transfer");

    a_nfc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nfc[CW] |-> r_nfc[CW-1:0] == '0)
        else $error("next free code beyond the code space");

endmodule

>>> design/lzwc_ctrl.sv
// Controller state machine that sequences lookup, insert, packing and dictionary clears.
module lzwc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  lzwc_pkg::t_sts i_sts,
    output lzwc_pkg::t_cmd o_cmd
);

    lzwc_pkg::t_state r_state, n_state;
    logic             r_need_clear, n_need_clear;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lzwc_pkg::S_CLEAR;
            r_need_clear <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_need_clear <= n_need_clear;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_need_clear = r_need_clear;
        o_cmd        = '0;
        o_cmd.put_sel = lzwc_pkg::PUT_PREFIX;
        o_in_ready   = 1'b0;
        case (r_state)
            lzwc_pkg::S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_done) begin
                    n_need_clear = 1'b0;
                    n_state      = lzwc_pkg::S_IDLE;
                end
            end
            lzwc_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.have_prefix ? lzwc_pkg::S_HASH : lzwc_pkg::S_TAIL;
                end
            end
            lzwc_pkg::S_HASH: begin
                if (!i_sts.have_prefix) begin
                    n_state = lzwc_pkg::S_TAIL;
                end else begin
                    o_cmd.hash = 1'b1;
                    n_state    = lzwc_pkg::S_READ;
                end
            end
            lzwc_pkg::S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = lzwc_pkg::S_CMP;
            end
            lzwc_pkg::S_CMP: begin
                if (!i_sts.entry_valid) begin
                    o_cmd.insert = 1'b1;
                    n_state      = lzwc_pkg::S_PUT_PREFIX;
                end else if (i_sts.entry_match) begin
                    o_cmd.hit = 1'b1;
                    n_state   = lzwc_pkg::S_TAIL;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = lzwc_pkg::S_READ;
                end
            end
            lzwc_pkg::S_PUT_PREFIX: begin
                if (i_sts.out_free) begin
                    o_cmd.put     = 1'b1;
                    o_cmd.restart = 1'b1;
                    if (!i_sts.width_full) begin
                        n_state = lzwc_pkg::S_TAIL;
                    end else if (i_sts.at_max) begin
                        n_state = lzwc_pkg::S_PUT_RESET;
                    end else begin
                        n_state = lzwc_pkg::S_PUT_GROW;
                    end
                end
            end
            lzwc_pkg::S_PUT_GROW: begin
                o_cmd.put_sel = lzwc_pkg::PUT_GROW;
                if (i_sts.out_free) begin
                    o_cmd.put  = 1'b1;
                    o_cmd.grow = 1'b1;
                    n_state    = lzwc_pkg::S_TAIL;
                end
            end
            lzwc_pkg::S_PUT_RESET: begin
                o_cmd.put_sel = lzwc_pkg::PUT_RESET;
                if (i_sts.out_free) begin
                    o_cmd.put        = 1'b1;
                    o_cmd.dict_reset = 1'b1;
                    n_need_clear     = 1'b1;
                    n_state          = lzwc_pkg::S_TAIL;
                end
            end
            lzwc_pkg::S_TAIL: begin
                // The first byte of a stream only becomes the prefix.
                if (!i_sts.have_prefix) begin
                    o_cmd.first = 1'b1;
                end
                n_state = i_sts.last ? lzwc_pkg::S_PUT_LASTP : lzwc_pkg::S_FINISH;
            end
            lzwc_pkg::S_PUT_LASTP: begin
                if (i_sts.out_free) begin
                    o_cmd.put = 1'b1;
                    n_state   = lzwc_pkg::S_PUT_END;
                end
            end
            lzwc_pkg::S_PUT_END: begin
                o_cmd.put_sel = lzwc_pkg::PUT_END;
                if (i_sts.out_free) begin
                    o_cmd.put = 1'b1;
                    n_state   = lzwc_pkg::S_FLUSH;
                end
            end
            lzwc_pkg::S_FLUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = lzwc_pkg::S_FINISH;
                end
            end
            lzwc_pkg::S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    if (i_sts.last) begin
                        o_cmd.stream_reset = 1'b1;
                        n_state            = lzwc_pkg::S_CLEAR;
                    end else if (r_need_clear) begin
                        n_state = lzwc_pkg::S_CLEAR;
                    end else begin
                        n_state = lzwc_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = lzwc_pkg::S_CLEAR;
            end
        endcase
    end

    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.clr_wr |-> !o_in_ready)
        else $error("input accepted during dictionary clear");

    a_insert_then_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.insert |=> r_state == lzwc_pkg::S_PUT_PREFIX)
        else $error("insert not followed by prefix output");

    a_read_then_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd |=> r_state == lzwc_pkg::S_CMP)
        else $error("dictionary read not followed by compare");

endmodule

>>> design/lzw_compressor_variable_width.sv
// Top level of the variable-width LZW compressor: controller plus datapath.
// Bytes enter one per transfer; codes of 9 up to MAX_CODE_BITS bits leave packed MSB-first
// in 16-bit words, several words per byte at most five. A stream's first byte passes idle,
// tail and finish; a dictionary hit passes idle, hash, read, compare, tail and finish, each
// extra probe being one read and one compare on the single read port of the dictionary RAM.
// A miss adds one state per emitted code (prefix, then grow or reset code if the width is
// full), and the last byte adds states for the prefix, end code and flush. After reset,
// after every reset code, and after the last byte of each stream the dictionary is cleared
// one entry per cycle, during which no byte is accepted. Words wait in an output register,
// so a stalled consumer holds up only the states that output a code or flush, and finish.
module lzw_compressor_variable_width #(
    parameter int TABLE_SIZE    = lzwc_pkg::TABLE_SIZE_DEF,
    parameter int MAX_CODE_BITS = lzwc_pkg::MAX_CODE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_packed_word,
    output logic        o_last_of_run,
    output logic        o_end_of_stream
);

    lzwc_pkg::t_cmd cmd;
    lzwc_pkg::t_sts sts;

    lzwc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lzwc_datapath #(
        .TABLE_SIZE    (TABLE_SIZE),
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_data_byte     (i_data_byte),
        .i_last_byte     (i_last_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_packed_word   (o_packed_word),
        .o_last_of_run   (o_last_of_run),
        .o_end_of_stream (o_end_of_stream)
    );

endmodule
